>>> rtl/trapped_water_volume_top_defines.svh
// assertion macros shared by the trapped water volume rtl
`ifndef TRAPPED_WATER_VOLUME_TOP_DEFINES_SVH
`define TRAPPED_WATER_VOLUME_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TWV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TWV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/twv_pkg.sv
// package: constants and interface types of the trapped water volume block
`timescale 1ns / 1ps

package twv_pkg;

	localparam int MAX_BARS_DEF    = 1024;
	localparam int HEIGHT_BITS_DEF = 16;
	localparam int IN_HEIGHT_W     = 16;
	localparam int TOTAL_W         = 26;
	localparam int S_TDATA_W       = 16;
	localparam int M_TDATA_W       = 32;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// requests from the load control to the walk engine
	typedef struct packed {
		logic start;
		logic ack;
	} twv_walk_ctrl_t;

	// walk engine status
	typedef struct packed {
		logic busy;
		logic done;
	} twv_walk_stat_t;

endpackage

>>> rtl/twv_ram.sv
// generic ram: one write port, two registered read ports
`timescale 1ns / 1ps

module twv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic [WIDTH-1:0]         rd_data_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

>>> rtl/twv_walk.sv
// two-pointer walk engine over the height memory
`timescale 1ns / 1ps

module twv_walk
	import twv_pkg::*;
#(
	parameter int MAX_BARS    = MAX_BARS_DEF,
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
	localparam int AW = $clog2(MAX_BARS),
	localparam int CW = $clog2(MAX_BARS + 1),
	localparam int SW = AW + HEIGHT_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  twv_walk_ctrl_t         ctrl,
	output twv_walk_stat_t         stat,
	input  logic [CW-1:0]          bar_count,
	output logic [AW-1:0]          rd_addr_a,
	input  logic [HEIGHT_BITS-1:0] rd_data_a,
	output logic [AW-1:0]          rd_addr_b,
	input  logic [HEIGHT_BITS-1:0] rd_data_b,
	output logic [SW-1:0]          sum
);

	`include "trapped_water_volume_top_defines.svh"

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_FILL   = 4'b0010,
		ST_STEP   = 4'b0100,
		ST_FINISH = 4'b1000
	} walk_state_t;

	walk_state_t            st_q;
	logic [AW-1:0]          l_q, r_q;
	logic [HEIGHT_BITS-1:0] hl_q, hr_q, lmax_q, rmax_q;
	logic [SW-1:0]          sum_q;

	logic                   go_left;
	logic [HEIGHT_BITS-1:0] lmax_nx, rmax_nx, gain;

	// the lower end is processed; h[l+1] and h[r-1] are already in the ram outputs
	assign go_left = hl_q < hr_q;
	assign lmax_nx = (hl_q > lmax_q) ? hl_q : lmax_q;
	assign rmax_nx = (hr_q > rmax_q) ? hr_q : rmax_q;
	assign gain    = go_left ? (lmax_nx - hl_q) : (rmax_nx - hr_q);

	always_comb begin
		rd_addr_a = l_q + AW'(1);
		rd_addr_b = r_q - AW'(1);
		unique case (st_q)
			ST_IDLE: begin
				rd_addr_a = '0;
				rd_addr_b = AW'(bar_count - CW'(1));
			end
			ST_FILL: begin
				rd_addr_a = l_q + AW'(1);
				rd_addr_b = r_q - AW'(1);
			end
			ST_STEP: begin
				// prefetch the neighbor after the one that moves in now
				if (go_left) begin
					rd_addr_a = l_q + AW'(2);
					rd_addr_b = r_q - AW'(1);
				end else begin
					rd_addr_a = l_q + AW'(1);
					rd_addr_b = r_q - AW'(2);
				end
			end
			ST_FINISH: begin
				rd_addr_a = l_q;
				rd_addr_b = r_q;
			end
			default: begin
				rd_addr_a = l_q;
				rd_addr_b = r_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						st_q <= (bar_count >= CW'(2)) ? ST_FILL : ST_FINISH;
					end
				end
				ST_FILL: begin
					st_q <= ST_STEP;
				end
				ST_STEP: begin
					if (l_q >= r_q) begin
						st_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (ctrl.ack) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					l_q    <= '0;
					r_q    <= AW'(bar_count - CW'(1));
					sum_q  <= '0;
					lmax_q <= '0;
					rmax_q <= '0;
				end
			end
			ST_FILL: begin
				hl_q <= rd_data_a;
				hr_q <= rd_data_b;
			end
			ST_STEP: begin
				if (l_q < r_q) begin
					sum_q <= sum_q + SW'(gain);
					if (go_left) begin
						lmax_q <= lmax_nx;
						l_q    <= l_q + AW'(1);
						hl_q   <= rd_data_a;
					end else begin
						rmax_q <= rmax_nx;
						r_q    <= r_q - AW'(1);
						hr_q   <= rd_data_b;
					end
				end
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (st_q != ST_IDLE);
	assign stat.done = (st_q == ST_FINISH);
	assign sum       = sum_q;

	`TWV_ASSERT_NOW(a_ptr_order, clk, arst_n, st_q == ST_STEP, l_q <= r_q,
		"walk pointers crossed")
	`TWV_ASSERT_NEXT(a_sum_grows, clk, arst_n, st_q == ST_STEP, sum_q >= $past(sum_q),
		"running total decreased during walk")
	`TWV_ASSERT_NEXT(a_done_holds, clk, arst_n, stat.done && !ctrl.ack, stat.done,
		"walk result dropped before it was taken")

endmodule

>>> rtl/trapped_water_volume_top.sv
// top level: bar loading, height memory, walk engine and result register
`timescale 1ns / 1ps

// trapped water volume. bars stream in on the slave side, one word per bar, and the
// word with tlast closes the profile. each bar is written into the height memory as
// it is taken. after the last bar the walk engine runs the two-pointer method over
// the stored profile using both read ports of the memory: a step to start, one to
// prime the read ports, then one step per bar passed (bar count minus one), one more
// in which the pointers are seen to meet and one to hand the total over (a single
// bar skips straight to the hand-over). the step loop through the memory read ports
// sets the pace of the walk. no bar is taken while the walk runs. the result sits in
// an output register, so loading of the next profile goes on while the total waits
// on the master side; a second total that finds the register still full holds the
// walk until it drains. bars beyond MAX_BARS are dropped and reported in tuser; the
// total saturates at 2^26 - 1. a profile of one bar gives a total of zero.

module trapped_water_volume_top
	import twv_pkg::*;
#(
	parameter int MAX_BARS    = MAX_BARS_DEF,
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// slave side: one bar per word
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] bar_height
	input  logic                 s_tlast,   // last_bar
	// master side: one total per profile
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [25:0] water_total, [31:26] zero
	output logic                 m_tuser    // [0] overflowed
);

	`include "trapped_water_volume_top_defines.svh"

	localparam int AW   = $clog2(MAX_BARS);
	localparam int CW   = $clog2(MAX_BARS + 1);
	localparam int SW   = AW + HEIGHT_BITS;
	localparam int CMPW = (SW > TOTAL_W) ? SW : TOTAL_W;

	typedef enum logic [1:0] {
		MD_LOAD = 2'b01,
		MD_RUN  = 2'b10
	} mode_t;

	mode_t                  mode_q;
	logic [CW-1:0]          count_q;     // bars stored so far
	logic                   drop_q;      // a bar was dropped on a full store
	logic                   start_q;     // kicks the walk once the last bar is written
	logic                   out_valid_q;
	logic [TOTAL_W-1:0]     total_q;
	logic                   ovf_q;

	logic                   accept;
	logic                   room;
	logic                   take_result;
	twv_walk_ctrl_t         walk_ctrl;
	twv_walk_stat_t         walk_stat;
	logic [AW-1:0]          rd_addr_a, rd_addr_b;
	logic [HEIGHT_BITS-1:0] rd_data_a, rd_data_b;
	logic [SW-1:0]          walk_sum;
	logic [CMPW-1:0]        sum_ext;
	logic [TOTAL_W-1:0]     total_sat;

	assign s_tready = (mode_q == MD_LOAD);
	assign accept   = s_tvalid && s_tready;
	assign room     = (count_q < CW'(MAX_BARS));

	// the result register is free when empty or being drained this cycle
	assign take_result = (mode_q == MD_RUN) && walk_stat.done && (!out_valid_q || m_tready);

	assign walk_ctrl.start = start_q;
	assign walk_ctrl.ack   = take_result;

	// saturate the walk total to the output field
	assign sum_ext   = CMPW'(walk_sum);
	assign total_sat = (sum_ext > CMPW'(TOTAL_MAX)) ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];

	twv_ram #(
		.WIDTH (HEIGHT_BITS),
		.DEPTH (MAX_BARS)
	) u_height_ram (
		.clk       (clk),
		.wr_en     (accept && room),
		.wr_addr   (count_q[AW-1:0]),
		.wr_data   (HEIGHT_BITS'(s_tdata)),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_data_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_data_b)
	);

	twv_walk #(
		.MAX_BARS    (MAX_BARS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (walk_ctrl),
		.stat      (walk_stat),
		.bar_count (count_q),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_data_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_data_b),
		.sum       (walk_sum)
	);

	// load control and profile bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MD_LOAD;
			count_q <= '0;
			drop_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (mode_q)
				MD_LOAD: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + CW'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (s_tlast) begin
							mode_q  <= MD_RUN;
							start_q <= 1'b1;
						end
					end
				end
				MD_RUN: begin
					if (take_result) begin
						mode_q  <= MD_LOAD;
						count_q <= '0;
						drop_q  <= 1'b0;
					end
				end
				default: begin
					mode_q <= MD_LOAD;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_result) begin
			total_q <= total_sat;
			ovf_q   <= drop_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(total_q);
	assign m_tuser  = ovf_q;

	`TWV_ASSERT_NOW(a_no_load_in_walk, clk, arst_n, walk_stat.busy, !s_tready,
		"bar taken while the walk runs")
	`TWV_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(MAX_BARS),
		"bar count beyond store capacity")

endmodule
